FILE: hdl/aes192_pkg.sv
// Shared AES-192 definitions: S-box tables, column mixing, stage tag type.
// No dependencies.
package aes192_pkg;

	localparam int NumRounds = 12;
	localparam int NumWords = 52;
	localparam int KeyRegs = 3;

	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;

	localparam logic REQ_ENC = 1'b0;
	localparam logic REQ_DEC = 1'b1;

	typedef struct packed {
		logic valid;
		logic dec;
	} tag_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// one column, byte 0 in bits 7:0
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[7:0];
		a1 = c[15:8];
		a2 = c[23:16];
		a3 = c[31:24];
		mix_col[7:0]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
		mix_col[15:8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
		mix_col[23:16] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
		mix_col[31:24] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		logic [7:0] x2, x4, x8;
		for (int i = 0; i < 4; i++) begin
			a[i] = c[8*i +: 8];
			x2 = xtime(a[i]);
			x4 = xtime(x2);
			x8 = xtime(x4);
			m9[i] = x8 ^ a[i];
			m11[i] = x8 ^ x2 ^ a[i];
			m13[i] = x8 ^ x4 ^ a[i];
			m14[i] = x8 ^ x4 ^ x2;
		end
		inv_mix_col[7:0]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
		inv_mix_col[15:8]  = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
		inv_mix_col[23:16] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
		inv_mix_col[31:24] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
	endfunction

endpackage

FILE: hdl/aes192_key_exp.sv
// Key registers and word-serial AES-192 key expansion, plus inverse-cipher words.
// Depends on aes192_pkg.
module aes192_key_exp import aes192_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [1:0]               wr_index,
	input  logic [63:0]              wr_data,
	output logic                     ready,
	output logic [NumWords-1:0][31:0] enc_words,
	output logic [NumWords-1:0][31:0] dec_words
);

	logic [63:0] key_q [KeyRegs];
	logic        ready_q;
	logic [5:0]  cnt_q;
	logic [2:0]  phase_q;   // cnt mod 6
	logic [7:0]  rcon_q;
	logic [31:0] win_q [6];
	logic [NumWords-1:0][31:0] ew_q;
	logic [NumWords-1:0][31:0] dw_q;
	logic [31:0] word;
	logic [31:0] t;
	logic [31:0] seed;
	logic        key_wr;

	assign key_wr = wr_en && (wr_index == REG_KEY0 || wr_index == REG_KEY1 ||
		wr_index == REG_KEY2);

	always_comb begin
		unique case (cnt_q[2:0])
			3'd0: seed = key_q[0][31:0];
			3'd1: seed = key_q[0][63:32];
			3'd2: seed = key_q[1][31:0];
			3'd3: seed = key_q[1][63:32];
			3'd4: seed = key_q[2][31:0];
			3'd5: seed = key_q[2][63:32];
			default: seed = 32'h0;
		endcase
		t = win_q[5];
		if (phase_q == 3'd0) begin
			t = {SBOX[win_q[5][7:0]], SBOX[win_q[5][31:24]], SBOX[win_q[5][23:16]],
				SBOX[win_q[5][15:8]] ^ rcon_q};
		end
		word = (cnt_q < 6'd6) ? seed : (win_q[0] ^ t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			cnt_q <= '0;
			phase_q <= '0;
			rcon_q <= 8'h01;
			for (int i = 0; i < KeyRegs; i++) key_q[i] <= '0;
		end else if (key_wr) begin
			key_q[wr_index] <= wr_data;
			ready_q <= 1'b0;
			cnt_q <= '0;
			phase_q <= '0;
			rcon_q <= 8'h01;
		end else if (!ready_q) begin
			cnt_q <= cnt_q + 6'd1;
			phase_q <= (phase_q == 3'd5) ? 3'd0 : phase_q + 3'd1;
			if (cnt_q >= 6'd6 && phase_q == 3'd0) rcon_q <= xtime(rcon_q);
			if (cnt_q == 6'(NumWords - 1)) ready_q <= 1'b1;
		end
	end

	// payload: window and word stores
	always_ff @(posedge clk) begin
		if (!ready_q && !key_wr) begin
			for (int i = 0; i < 5; i++) win_q[i] <= win_q[i+1];
			win_q[5] <= word;
			ew_q[cnt_q] <= word;
			dw_q[cnt_q] <= inv_mix_col(word);
		end
	end

	assign ready = ready_q;
	assign enc_words = ew_q;
	assign dec_words = dw_q;

endmodule

FILE: hdl/aes192_round_cell.sv
// One registered AES round, encrypt or decrypt per beat.
// Depends on aes192_pkg.
module aes192_round_cell import aes192_pkg::*; #(
	parameter bit Last = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  tag_t         tag_in,
	input  logic [127:0] state_in,
	input  logic [127:0] enc_key,
	input  logic [127:0] dec_key,
	output tag_t         tag_out,
	output logic [127:0] state_out
);

	tag_t         tag_q;
	logic [127:0] st_q;
	logic [127:0] ss, mx, nxt;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (tag_in.dec == REQ_DEC)
					ss[8*(r+4*c) +: 8] = INV_SBOX[state_in[8*(r+4*((c-r)&3)) +: 8]];
				else
					ss[8*(r+4*c) +: 8] = SBOX[state_in[8*(r+4*((c+r)&3)) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (Last)
				mx[32*c +: 32] = ss[32*c +: 32];
			else if (tag_in.dec == REQ_DEC)
				mx[32*c +: 32] = inv_mix_col(ss[32*c +: 32]);
			else
				mx[32*c +: 32] = mix_col(ss[32*c +: 32]);
		end
		nxt = mx ^ ((tag_in.dec == REQ_DEC) ? dec_key : enc_key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_q <= '0;
		else if (en) tag_q <= tag_in;
	end

	always_ff @(posedge clk) begin
		if (en) st_q <= nxt;
	end

	assign tag_out = tag_q;
	assign state_out = st_q;

endmodule

FILE: hdl/aes192_block_cipher_top.sv
// AES-192 engine top: key expansion unit and a chain of twelve round cells.
// Depends on aes192_pkg, aes192_key_exp, aes192_round_cell.
//
//  channel | direction | signals                          | beat
//  --------+-----------+----------------------------------+--------------------------
//  s       | in        | s_tvalid s_tready s_tdata s_tuser | one block + request type
//  m       | out       | m_tvalid m_tready m_tdata         | one result block
//  cfg     | in        | wr_en wr_index wr_data            | one key register write
//
// One block enters per cycle while s_tready is high; each result passes one key-add
// stage plus twelve round cells and leaves one per cycle while m is not stalled.
// After reset and after any key write the expansion unit produces one key
// word per cycle, 52 words in all, while s_tready stays low.
// A stall on m freezes the whole chain; s_tready falls with it.
module aes192_block_cipher_top import aes192_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // block_lo[63:0], block_hi[127:64]
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // result_lo[63:0], result_hi[127:64]
	input  logic         wr_en,
	input  logic [1:0]   wr_index,
	input  logic [63:0]  wr_data
);

	logic                      ready;
	logic [NumWords-1:0][31:0] enc_words;
	logic [NumWords-1:0][31:0] dec_words;
	logic                      en;
	tag_t                      tag_s [NumRounds+1];
	logic [127:0]              st_s [NumRounds+1];
	tag_t                      tag_s0;
	logic [127:0]              st_s0;
	logic [127:0]              rk0, rk12;

	aes192_key_exp u_kx (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.ready     (ready),
		.enc_words (enc_words),
		.dec_words (dec_words)
	);

	// whole chain advances unless the result is held
	assign en = !tag_s[NumRounds].valid || m_tready;
	assign s_tready = en && ready;

	assign rk0 = {enc_words[3], enc_words[2], enc_words[1], enc_words[0]};
	assign rk12 = {enc_words[4*NumRounds+3], enc_words[4*NumRounds+2],
		enc_words[4*NumRounds+1], enc_words[4*NumRounds]};

	// entry stage: initial whitening key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s0 <= '0;
		end else if (en) begin
			tag_s0.valid <= s_tvalid && ready;
			tag_s0.dec <= s_tuser;
		end
	end

	always_ff @(posedge clk) begin
		if (en) st_s0 <= s_tdata ^ ((s_tuser == REQ_DEC) ? rk12 : rk0);
	end

	assign tag_s[0] = tag_s0;
	assign st_s[0] = st_s0;

	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		logic [127:0] ek, dk;
		assign ek = {enc_words[4*r+3], enc_words[4*r+2], enc_words[4*r+1], enc_words[4*r]};
		if (r == NumRounds) begin : g_last
			assign dk = rk0;
		end else begin : g_mid
			assign dk = {dec_words[4*(NumRounds-r)+3], dec_words[4*(NumRounds-r)+2],
				dec_words[4*(NumRounds-r)+1], dec_words[4*(NumRounds-r)]};
		end
		aes192_round_cell #(.Last(r == NumRounds)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.tag_in    (tag_s[r-1]),
			.state_in  (st_s[r-1]),
			.enc_key   (ek),
			.dec_key   (dk),
			.tag_out   (tag_s[r]),
			.state_out (st_s[r])
		);
	end

	assign m_tvalid = tag_s[NumRounds].valid;
	assign m_tdata = st_s[NumRounds];

endmodule
